@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bbd_pkg.sv @@
// ----------------------------------------------------------------------------
// bbd_pkg
// types and codes shared by the bitset domain and its checker
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam int CHUNK_W = 8;   // bits handled by the scan unit per cycle
  localparam int VAL_W   = 6;
  localparam int CNT_W   = 7;
  localparam int ACT_W   = 3;
  localparam int SLVL_W  = 8;

  localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REDUCE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ADD     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RESTORE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_POP_LD,
    S_EDIT,
    S_SCAN,
    S_OUT
  } bbd_state_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [VAL_W-1:0]  value_index;
    logic [SLVL_W-1:0] search_level;
  } bbd_in_t;

  typedef struct packed {
    logic             contains;
    logic             next_found;
    logic [VAL_W-1:0] next_value;
    logic             prev_found;
    logic [VAL_W-1:0] prev_value;
    logic [VAL_W-1:0] first_value;
    logic [VAL_W-1:0] last_value;
    logic             domain_empty;
    logic [CNT_W-1:0] present_count;
    logic             trail_full;
  } bbd_out_t;

endpackage

@@ hdl/backtrackable_bitset_domain.sv @@
// ----------------------------------------------------------------------------
// backtrackable_bitset_domain
// value domain of one solver variable as a bitset with a trail of snapshots
// ----------------------------------------------------------------------------
// One word in, one word out. The top snapshot lives in registers; older
// snapshots sit in a single-port trail memory (one write or one read per
// cycle, registered read). A word is taken only in the idle state, and the
// block stays busy until its result is placed in the output register, which
// can hold one finished result while the next word is already being worked.
// Query goes straight to the scan and add edits the top first; restore pops
// the snapshots above its level, and remove and reduce pop and then edit,
// before the scan. Each pop reads one snapshot through the memory read port
// in S_POP and loads it in S_POP_LD; the result comes from one shared scan
// unit that walks the top snapshot eight bits a cycle, building membership,
// neighbors, extremes and count. After reset and after a write of domain_size
// the block is ready at once; no clearing pass is needed.
module backtrackable_bitset_domain #(
  parameter int MAX_VALUES  = 64,
  parameter int TRAIL_DEPTH = 64,
  parameter int LEVEL_BITS  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bbd_pkg::bbd_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bbd_pkg::bbd_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [bbd_pkg::CNT_W-1:0] cfg_data
);

  localparam int NCHUNK = (MAX_VALUES + bbd_pkg::CHUNK_W - 1) / bbd_pkg::CHUNK_W;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int SCAN_W = NCHUNK * bbd_pkg::CHUNK_W;
  localparam int PW     = $clog2(TRAIL_DEPTH);
  localparam int ENT_W  = LEVEL_BITS + MAX_VALUES;

  bbd_pkg::bbd_state_t state_r, state_nxt;

  logic [MAX_VALUES-1:0] mask_r, mask_nxt;
  logic [MAX_VALUES-1:0] top_bits_r, top_bits_nxt;
  logic [LEVEL_BITS-1:0] top_lvl_r, top_lvl_nxt;
  logic [PW-1:0]         ptr_r, ptr_nxt;

  logic [bbd_pkg::ACT_W-1:0] act_r, act_nxt;
  logic [bbd_pkg::VAL_W-1:0] v_r, v_nxt;
  logic [LEVEL_BITS-1:0]     lvl_r, lvl_nxt;
  logic                      full_r, full_nxt;

  logic [CW-1:0]       chunk_r, chunk_nxt;
  bbd_pkg::bbd_out_t   acc_r, acc_nxt;
  bbd_pkg::bbd_out_t   out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;

  // trail memory: {level, bits} of every snapshot below the top
  logic [ENT_W-1:0] trail_mem [TRAIL_DEPTH];
  logic [ENT_W-1:0] rd_data_r;
  logic             mem_we, mem_re;

  logic [MAX_VALUES-1:0]       sel_bit;
  logic [MAX_VALUES-1:0]       new_mask;
  logic [SCAN_W-1:0]           scan_word;
  logic [bbd_pkg::CHUNK_W-1:0] chunk_bits;
  logic [bbd_pkg::VAL_W-1:0]   pos;
  bbd_pkg::bbd_out_t           scan;

  // one-hot of the addressed value, limited to the domain, and the mask for a new domain size
  always_comb begin
    for (int i = 0; i < MAX_VALUES; i++) begin
      sel_bit[i]  = mask_r[i] && (v_r == bbd_pkg::VAL_W'(i));
      new_mask[i] = bbd_pkg::CNT_W'(i) < cfg_data;
    end
  end

  // shared scan unit: one chunk of the top snapshot per cycle
  always_comb begin
    scan_word  = SCAN_W'(top_bits_r & mask_r);
    chunk_bits = scan_word[chunk_r*bbd_pkg::CHUNK_W +: bbd_pkg::CHUNK_W];
    scan       = (chunk_r == '0) ? '0 : acc_r;
    pos        = '0;
    for (int p = 0; p < bbd_pkg::CHUNK_W; p++) begin
      pos = bbd_pkg::VAL_W'(int'(chunk_r) * bbd_pkg::CHUNK_W + p);
      if (chunk_bits[p]) begin
        if (scan.present_count == '0) begin
          scan.first_value = pos;
        end
        scan.last_value    = pos;
        scan.present_count = scan.present_count + bbd_pkg::CNT_W'(1);
        if (pos == v_r) begin
          scan.contains = 1'b1;
        end
        if (pos > v_r && !scan.next_found) begin
          scan.next_found = 1'b1;
          scan.next_value = pos;
        end
        if (pos < v_r) begin
          scan.prev_found = 1'b1;
          scan.prev_value = pos;
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mask_nxt      = mask_r;
    top_bits_nxt  = top_bits_r;
    top_lvl_nxt   = top_lvl_r;
    ptr_nxt       = ptr_r;
    act_nxt       = act_r;
    v_nxt         = v_r;
    lvl_nxt       = lvl_r;
    full_nxt      = full_r;
    chunk_nxt     = chunk_r;
    acc_nxt       = acc_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    cfg_ready     = (state_r == bbd_pkg::S_IDLE);
    in_ready      = (state_r == bbd_pkg::S_IDLE) && !cfg_valid;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bbd_pkg::S_IDLE: begin
        if (cfg_valid) begin
          // new domain size restarts the trail
          mask_nxt     = new_mask;
          top_bits_nxt = new_mask;
          top_lvl_nxt  = '0;
          ptr_nxt      = '0;
        end else if (in_valid) begin
          act_nxt   = in_data.action;
          v_nxt     = in_data.value_index;
          lvl_nxt   = LEVEL_BITS'(in_data.search_level);
          full_nxt  = 1'b0;
          chunk_nxt = '0;
          if (in_data.action == bbd_pkg::ACT_REMOVE ||
              in_data.action == bbd_pkg::ACT_REDUCE ||
              in_data.action == bbd_pkg::ACT_RESTORE) begin
            state_nxt = bbd_pkg::S_POP;
          end else if (in_data.action == bbd_pkg::ACT_ADD) begin
            state_nxt = bbd_pkg::S_EDIT;
          end else begin
            state_nxt = bbd_pkg::S_SCAN;
          end
        end
      end
      bbd_pkg::S_POP: begin
        if (ptr_r != '0 && top_lvl_r > lvl_r) begin
          mem_re    = 1'b1;
          state_nxt = bbd_pkg::S_POP_LD;
        end else if (act_r == bbd_pkg::ACT_RESTORE) begin
          state_nxt = bbd_pkg::S_SCAN;
        end else begin
          state_nxt = bbd_pkg::S_EDIT;
        end
      end
      bbd_pkg::S_POP_LD: begin
        top_lvl_nxt  = rd_data_r[ENT_W-1:MAX_VALUES];
        top_bits_nxt = rd_data_r[MAX_VALUES-1:0];
        ptr_nxt      = ptr_r - PW'(1);
        state_nxt    = bbd_pkg::S_POP;
      end
      bbd_pkg::S_EDIT: begin
        if (act_r == bbd_pkg::ACT_ADD) begin
          top_bits_nxt = top_bits_r | sel_bit;
        end else begin
          if (top_lvl_r < lvl_r) begin
            // push: old top goes to the trail unless it is full, the register keeps the copy
            if (ptr_r != PW'(TRAIL_DEPTH - 1)) begin
              mem_we  = 1'b1;
              ptr_nxt = ptr_r + PW'(1);
            end else begin
              full_nxt = 1'b1;
            end
          end
          if (act_r == bbd_pkg::ACT_REMOVE) begin
            top_bits_nxt = top_bits_r & ~sel_bit;
          end else begin
            top_bits_nxt = sel_bit;
          end
          top_lvl_nxt = lvl_r;
        end
        state_nxt = bbd_pkg::S_SCAN;
      end
      bbd_pkg::S_SCAN: begin
        acc_nxt   = scan;
        chunk_nxt = chunk_r + CW'(1);
        if (chunk_r == CW'(NCHUNK - 1)) begin
          state_nxt = bbd_pkg::S_OUT;
        end
      end
      bbd_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt              = acc_r;
          out_data_nxt.domain_empty = (acc_r.present_count == '0);
          out_data_nxt.trail_full   = full_r;
          out_valid_nxt             = 1'b1;
          state_nxt                 = bbd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bbd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbd_pkg::S_IDLE;
      mask_r      <= '1;
      top_bits_r  <= '1;
      top_lvl_r   <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      top_bits_r  <= top_bits_nxt;
      top_lvl_r   <= top_lvl_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    v_r        <= v_nxt;
    lvl_r      <= lvl_nxt;
    full_r     <= full_nxt;
    chunk_r    <= chunk_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      trail_mem[ptr_r] <= {top_lvl_r, top_bits_r};
    end
    if (mem_re) begin
      rd_data_r <= trail_mem[ptr_r - PW'(1)];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/bbd_checker.sv @@
// ----------------------------------------------------------------------------
// bbd_checker
// port-level checks on the bitset domain, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input bbd_pkg::bbd_out_t out_data
);

  // a stalled result word holds
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")

  // one word at a time: busy right after an accept
  `ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted on back-to-back cycles")

  // empty flag agrees with the count
  `ASSERT_IMP(a_empty_count, clk, rst_n, out_valid, out_data.domain_empty == (out_data.present_count == '0), "empty flag disagrees with count")

  // empty domain reports nothing present
  `ASSERT_IMP(a_empty_fields, clk, rst_n, out_valid && out_data.domain_empty, !out_data.contains && !out_data.next_found && !out_data.prev_found && out_data.first_value == '0 && out_data.last_value == '0, "empty domain reports a present value")

  // missing neighbors read as zero
  `ASSERT_IMP(a_neighbor_zero, clk, rst_n, out_valid, (out_data.next_found || out_data.next_value == '0) && (out_data.prev_found || out_data.prev_value == '0), "missing neighbor value not zero")

endmodule

bind backtrackable_bitset_domain bbd_checker u_bbd_checker (.*);

@@ tb/tb_backtrackable_bitset_domain.sv @@
// ----------------------------------------------------------------------------
// tb_backtrackable_bitset_domain
// self-checking bench for the trailed bitset domain
// ----------------------------------------------------------------------------
// A class tracks the trail of snapshots, predicts the full result word for
// every accepted command word and checks the words that come out in order.
// The stimulus starts with hand-picked commands and then runs search-like
// sequences of removes, reductions, add-backs and restores across several
// domain sizes, with deep dives that fill the trail, random noise words,
// random stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_backtrackable_bitset_domain;

  localparam int TRAIL_N = 64;

  class domain_tracker;
    localparam int DEPTH = 64;

    logic [63:0]                snap_bits [DEPTH];
    logic [bbd_pkg::SLVL_W-1:0] snap_lvl [DEPTH];
    int unsigned                top;
    logic [bbd_pkg::CNT_W-1:0]  size_reg;
    bbd_pkg::bbd_out_t          awaited [$];
    int                         errors;
    int                         words;
    int                         results;
    int                         full_hits;
    int                         deepest;

    function new();
      errors    = 0;
      words     = 0;
      results   = 0;
      full_hits = 0;
      deepest   = 0;
      set_size(bbd_pkg::CNT_W'(64));
    endfunction

    function logic [63:0] live_mask();
      int n;
      n = (size_reg > 64) ? 64 : int'(size_reg);
      if (n >= 64) return '1;
      return (64'd1 << n) - 64'd1;
    endfunction

    // a size write rebuilds the trail from scratch
    function void set_size(logic [bbd_pkg::CNT_W-1:0] sz);
      size_reg = sz;
      foreach (snap_bits[i]) begin
        snap_bits[i] = '0;
        snap_lvl[i]  = '0;
      end
      snap_bits[0] = live_mask();
      top = 0;
    endfunction

    function void pop_above(logic [bbd_pkg::SLVL_W-1:0] lvl);
      while (top > 0 && snap_lvl[top] > lvl) top--;
    endfunction

    // returns 1 when a push was needed but the trail had no room
    function bit lift(logic [bbd_pkg::SLVL_W-1:0] lvl, bit copy);
      if (snap_lvl[top] < lvl) begin
        if (top + 1 < DEPTH) begin
          top++;
          if (copy) snap_bits[top] = snap_bits[top-1];
        end else begin
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void take_word(bbd_pkg::bbd_in_t w);
      logic [63:0]       msk;
      logic [63:0]       hit;
      logic [63:0]       d;
      bit                skipped;
      bit                seen;
      int                i;
      int                v;
      bbd_pkg::bbd_out_t r;
      msk     = live_mask();
      v       = int'(w.value_index);
      hit     = (64'd1 << v) & msk;
      skipped = 1'b0;
      seen    = 1'b0;
      r       = '0;
      case (w.action)
        bbd_pkg::ACT_REMOVE: begin
          pop_above(w.search_level);
          skipped = lift(w.search_level, 1'b1);
          snap_bits[top] &= ~hit;
          snap_lvl[top] = w.search_level;
        end
        bbd_pkg::ACT_REDUCE: begin
          pop_above(w.search_level);
          skipped = lift(w.search_level, 1'b0);
          snap_bits[top] = hit;
          snap_lvl[top] = w.search_level;
        end
        bbd_pkg::ACT_ADD: begin
          snap_bits[top] |= hit;
        end
        bbd_pkg::ACT_RESTORE: begin
          pop_above(w.search_level);
        end
        default: begin
        end
      endcase
      d = snap_bits[top] & msk;
      for (i = 0; i < 64; i++) begin
        if (d[i]) begin
          r.present_count = r.present_count + 1'b1;
          if (!seen) begin
            r.first_value = bbd_pkg::VAL_W'(i);
            seen = 1'b1;
          end
          r.last_value = bbd_pkg::VAL_W'(i);
          if (i > v && !r.next_found) begin
            r.next_found = 1'b1;
            r.next_value = bbd_pkg::VAL_W'(i);
          end
          if (i < v) begin
            r.prev_found = 1'b1;
            r.prev_value = bbd_pkg::VAL_W'(i);
          end
        end
      end
      r.contains     = d[v];
      r.domain_empty = (d == 64'd0);
      r.trail_full   = skipped;
      awaited = {awaited, r};
      words++;
      if (skipped) full_hits++;
      if (int'(top) > deepest) deepest = int'(top);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task cmp(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("word %0d %s got %0d want %0d", results, name, got, want));
    endtask

    task check_word(bbd_pkg::bbd_out_t got);
      bbd_pkg::bbd_out_t want;
      if (awaited.size() == 0) begin
        report("result word with no command outstanding");
        return;
      end
      want = awaited.pop_front();
      results++;
      cmp("contains", 8'(got.contains), 8'(want.contains));
      cmp("next_found", 8'(got.next_found), 8'(want.next_found));
      cmp("next_value", 8'(got.next_value), 8'(want.next_value));
      cmp("prev_found", 8'(got.prev_found), 8'(want.prev_found));
      cmp("prev_value", 8'(got.prev_value), 8'(want.prev_value));
      cmp("first_value", 8'(got.first_value), 8'(want.first_value));
      cmp("last_value", 8'(got.last_value), 8'(want.last_value));
      cmp("domain_empty", 8'(got.domain_empty), 8'(want.domain_empty));
      cmp("present_count", 8'(got.present_count), 8'(want.present_count));
      cmp("trail_full", 8'(got.trail_full), 8'(want.trail_full));
    endtask
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  bbd_pkg::bbd_in_t          in_data;
  logic                      out_valid;
  logic                      out_ready;
  bbd_pkg::bbd_out_t         out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [bbd_pkg::CNT_W-1:0] cfg_data;

  domain_tracker ledger;
  bit            calm = 1'b0;
  bit            hold_req = 1'b0;
  int            cur_level = 0;
  int            size_writes = 0;

  backtrackable_bitset_domain #(
    .MAX_VALUES  (64),
    .TRAIL_DEPTH (TRAIL_N),
    .LEVEL_BITS  (8)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(64'd8 * 64'd1_000_000);
    $display("tb: failure");
    $finish;
  end

  // result side: random stalls, a calm stretch and one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) ledger.check_word(out_data);
      if (hold_req) begin
        hold_left = 400;
        hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 13);
      end
    end
  end

  function automatic int pick_value(input int ds);
    int n;
    n = (ds > 64) ? 64 : ds;
    if (n == 0 || $urandom_range(0, 4) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, n - 1);
  endfunction

  // valid stays up between back-to-back words; it drops only for a gap or a settle
  task automatic send_op(input logic [bbd_pkg::ACT_W-1:0] act, input int v, input int lvl);
    bbd_pkg::bbd_in_t w;
    w.action       = act;
    w.value_index  = bbd_pkg::VAL_W'(v);
    w.search_level = bbd_pkg::SLVL_W'(lvl);
    if (!calm && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.take_word(w);
  endtask

  task automatic settle(input int tail);
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (ledger.awaited.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    if (ledger.awaited.size() != 0) begin
      $display("tb: failure");
      $finish;
    end
    repeat (tail) @(posedge clk);
  endtask

  task automatic load_domain_size(input logic [bbd_pkg::CNT_W-1:0] sz);
    cfg_valid <= 1'b1;
    cfg_data  <= sz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ledger.set_size(sz);
    size_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // search-shaped traffic: go deeper, prune, backtrack
  task automatic run_search(input int steps, input int ds);
    int k;
    int roll;
    int lvl;
    for (k = 0; k < steps; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        lvl = cur_level + (($urandom_range(0, 2) == 0) ? 1 : 0);
        if (lvl > 250) lvl = 250;
        send_op(bbd_pkg::ACT_REMOVE, pick_value(ds), lvl);
        cur_level = lvl;
      end else if (roll < 45) begin
        lvl = (cur_level < 250) ? cur_level + 1 : cur_level;
        send_op(bbd_pkg::ACT_REDUCE, pick_value(ds), lvl);
        cur_level = lvl;
      end else if (roll < 55) begin
        send_op(bbd_pkg::ACT_ADD, pick_value(ds), $urandom_range(0, 255));
      end else if (roll < 70) begin
        send_op(bbd_pkg::ACT_QUERY, $urandom_range(0, 63), $urandom_range(0, 255));
      end else if (roll < 85) begin
        lvl = $urandom_range(0, cur_level);
        send_op(bbd_pkg::ACT_RESTORE, $urandom_range(0, 63), lvl);
        cur_level = lvl;
      end else begin
        // edit at a shallower level, popping on the way
        lvl = $urandom_range(0, cur_level);
        send_op(bbd_pkg::ACT_REMOVE, pick_value(ds), lvl);
        cur_level = lvl;
      end
    end
  endtask

  // one push per level until the trail runs out of room
  task automatic run_dive(input int ds);
    int k;
    int n;
    send_op(bbd_pkg::ACT_RESTORE, $urandom_range(0, 63), 0);
    n = $urandom_range(64, 70);
    for (k = 1; k <= n; k++)
      send_op(($urandom_range(0, 9) == 0) ? bbd_pkg::ACT_REDUCE : bbd_pkg::ACT_REMOVE,
              pick_value(ds), k);
    cur_level = n;
  endtask

  task automatic run_noise(input int n);
    repeat (n)
      send_op(bbd_pkg::ACT_W'($urandom_range(0, 7)), $urandom_range(0, 63),
              $urandom_range(0, 255));
  endtask

  initial begin
    logic [bbd_pkg::CNT_W-1:0] sizes [8];
    int                        p;
    int                        target;
    int                        roll;
    bit                        hold_done;
    ledger    = new();
    hold_done = 1'b0;
    sizes     = '{7'd1, 7'd127, 7'd37, 7'd0, 7'd64, 7'd2, 7'd0, 7'd100};
    sizes[6]  = bbd_pkg::CNT_W'($urandom_range(3, 63));
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full domain out of reset
    send_op(bbd_pkg::ACT_QUERY, 0, 0);
    send_op(bbd_pkg::ACT_QUERY, 63, 255);
    send_op(bbd_pkg::ACT_REMOVE, 0, 0);
    send_op(bbd_pkg::ACT_REMOVE, 63, 1);
    send_op(bbd_pkg::ACT_REDUCE, 5, 2);
    send_op(bbd_pkg::ACT_ADD, 63, 0);
    send_op(bbd_pkg::ACT_QUERY, 5, 0);
    send_op(bbd_pkg::ACT_RESTORE, 0, 1);
    send_op(bbd_pkg::ACT_RESTORE, 63, 0);
    send_op(bbd_pkg::ACT_REMOVE, 32, 255);
    send_op(3'd5, 32, 0);
    send_op(3'd6, 0, 0);
    send_op(3'd7, 63, 0);
    send_op(bbd_pkg::ACT_RESTORE, 0, 0);
    send_op(bbd_pkg::ACT_REDUCE, 63, 3);
    send_op(bbd_pkg::ACT_REMOVE, 63, 3);
    send_op(bbd_pkg::ACT_QUERY, 0, 0);

    // empty domain: nothing can be added or kept
    settle(16);
    load_domain_size(bbd_pkg::CNT_W'(0));
    send_op(bbd_pkg::ACT_ADD, 3, 0);
    send_op(bbd_pkg::ACT_REDUCE, 3, 2);
    send_op(bbd_pkg::ACT_QUERY, 0, 0);

    // one-value domain, edits outside it
    settle(16);
    load_domain_size(bbd_pkg::CNT_W'(1));
    send_op(bbd_pkg::ACT_REDUCE, 40, 1);
    send_op(bbd_pkg::ACT_RESTORE, 0, 0);
    send_op(bbd_pkg::ACT_ADD, 63, 0);
    send_op(bbd_pkg::ACT_QUERY, 0, 0);

    for (p = 0; p < 8; p++) begin
      settle(16);
      calm = (p == 4);
      load_domain_size(sizes[p]);
      cur_level = 0;
      if (p == 4) run_dive(sizes[p]);
      target = ledger.words + 130;
      while (ledger.words < target) begin
        if (p == 2 && !hold_done && ledger.words > target - 125) begin
          hold_req <= 1'b1;
          hold_done = 1'b1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 62) run_search($urandom_range(6, 20), sizes[p]);
        else if (roll < 67) run_dive(sizes[p]);
        else run_noise($urandom_range(3, 10));
      end
    end
    calm = 1'b0;
    settle(150);

    if (ledger.awaited.size() != 0)
      ledger.report($sformatf("%0d result words never arrived", ledger.awaited.size()));
    $display("covered %0d command words and %0d result words over %0d domain sizes",
             ledger.words, ledger.results, size_writes);
    $display("deepest trail entry %0d, %0d pushes refused on a full trail, %0d errors",
             ledger.deepest, ledger.full_hits, ledger.errors);
    if (ledger.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
